/* rtl/vlsd_pkg.sv */
// ----------------------------------------------------------------------------
// vlsd_pkg: shared types, constants and helpers
// Widths, command and register codes, pipeline control bundle and the
// magnitude / saturation helpers used by the spring-damper force unit.
// ----------------------------------------------------------------------------
package vlsd_pkg;

	localparam int ROBOT_COUNT    = 8;
	localparam int ROBOT_W        = 3;
	localparam int IDX_W          = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;
	localparam int POS_W          = 32;
	localparam int MAG_W          = POS_W - 1;
	localparam int GAIN_W         = 16;
	localparam int PROD_W         = GAIN_W + POS_W;
	localparam int SUM_W          = PROD_W + 1;
	localparam int FRAC_SHIFT     = 8;
	localparam int SHR_W          = SUM_W - FRAC_SHIFT;
	localparam int WIDE_W         = SHR_W + 1;
	localparam int DIFF_W         = MAG_W + 2;
	localparam int RATE_W         = DIFF_W + 5;
	localparam int SAMPLE_RATE_HZ = 20;
	localparam int CFG_IDX_W      = 1;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic        [MAG_W-1:0]  mag_t;
	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_MEASURE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_SPRING = 1'b0,
		REG_GAIN_DAMPER = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic load_s2;
		logic load_out;
	} pipe_ctrl_t;

	// Magnitude with the most negative value clamped to the largest magnitude.
	function automatic mag_t mag31(input pos_t v);
		mag_t m;
		if (v[POS_W-1]) begin
			if (v == {1'b1, {(POS_W-1){1'b0}}}) begin
				m = '1;
			end else begin
				m = MAG_W'(-v);
			end
		end else begin
			m = v[MAG_W-1:0];
		end
		return m;
	endfunction

	// Saturate a wide signed value to the 32-bit signed range.
	function automatic pos_t sat32(input wide_t v);
		pos_t r;
		if ((&v[WIDE_W-1:POS_W-1]) || (~|v[WIDE_W-1:POS_W-1])) begin
			r = v[POS_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* rtl/vlsd_track.sv */
// ----------------------------------------------------------------------------
// vlsd_track: per-robot state and deviation tracking
// Holds reference magnitudes, previous deviations and deviation rates for
// each robot, computes this transaction's deviation and rate, and writes the
// updated entries back when the transaction leaves the first stage.
// ----------------------------------------------------------------------------
module vlsd_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  vlsd_pkg::cmd_t        cmd,
	input  logic [vlsd_pkg::IDX_W-1:0] idx,
	input  vlsd_pkg::pos_t        pos_x,
	input  vlsd_pkg::pos_t        pos_y,
	output vlsd_pkg::pos_t        dev_x,
	output vlsd_pkg::pos_t        dev_y,
	output vlsd_pkg::pos_t        rate_x,
	output vlsd_pkg::pos_t        rate_y
);
	import vlsd_pkg::*;

	mag_t ref_x_q  [ROBOT_COUNT];
	mag_t ref_y_q  [ROBOT_COUNT];
	pos_t prev_x_q [ROBOT_COUNT];
	pos_t prev_y_q [ROBOT_COUNT];
	pos_t rate_x_q [ROBOT_COUNT];
	pos_t rate_y_q [ROBOT_COUNT];

	mag_t mag_px, mag_py;
	pos_t prev_x, prev_y;
	logic both_nz;
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic signed [RATE_W-1:0] scaled_x, scaled_y;

	always_comb begin
		mag_px  = mag31(pos_x);
		mag_py  = mag31(pos_y);
		prev_x  = prev_x_q[idx];
		prev_y  = prev_y_q[idx];
		both_nz = (prev_x != '0) && (prev_y != '0);

		dev_x = pos_t'({1'b0, mag_px}) - pos_t'({1'b0, ref_x_q[idx]});
		dev_y = pos_t'({1'b0, mag_py}) - pos_t'({1'b0, ref_y_q[idx]});

		diff_x = {2'b00, mag31(dev_x)} - {2'b00, mag31(prev_x)};
		diff_y = {2'b00, mag31(dev_y)} - {2'b00, mag31(prev_y)};

		// Rate in units per second: change per sample times the sample rate.
		scaled_x = RATE_W'(diff_x) * RATE_W'(SAMPLE_RATE_HZ);
		scaled_y = RATE_W'(diff_y) * RATE_W'(SAMPLE_RATE_HZ);

		rate_x = both_nz ? sat32(WIDE_W'(scaled_x)) : rate_x_q[idx];
		rate_y = both_nz ? sat32(WIDE_W'(scaled_y)) : rate_y_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROBOT_COUNT; i++) begin
				ref_x_q[i]  <= '0;
				ref_y_q[i]  <= '0;
				prev_x_q[i] <= '0;
				prev_y_q[i] <= '0;
				rate_x_q[i] <= '0;
				rate_y_q[i] <= '0;
			end
		end else if (wr) begin
			unique case (cmd)
				CMD_LOAD: begin
					ref_x_q[idx] <= mag_px;
					ref_y_q[idx] <= mag_py;
				end
				CMD_MEASURE: begin
					prev_x_q[idx] <= dev_x;
					prev_y_q[idx] <= dev_y;
					rate_x_q[idx] <= rate_x;
					rate_y_q[idx] <= rate_y;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/vlsd_force_axis.sv */
// ----------------------------------------------------------------------------
// vlsd_force_axis: force for one axis
// Registers the spring and damper products, then sums, shifts back to
// Q16.16, applies the sign of the offset and saturates into the result.
// ----------------------------------------------------------------------------
module vlsd_force_axis (
	input  logic                 clk,
	input  vlsd_pkg::pipe_ctrl_t ctrl,
	input  vlsd_pkg::gain_t      gain_spring,
	input  vlsd_pkg::gain_t      gain_damper,
	input  vlsd_pkg::pos_t       dev,
	input  vlsd_pkg::pos_t       rate,
	input  vlsd_pkg::pos_t       pos,
	output vlsd_pkg::pos_t       force_q
);
	import vlsd_pkg::*;

	logic signed [PROD_W-1:0] prod_k_s2, prod_c_s2;
	logic                     neg_s2, zero_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SHR_W-1:0]  shifted;
	wide_t                    signed_force;

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prod_k_s2 <= PROD_W'(gain_spring) * PROD_W'(dev);
			prod_c_s2 <= PROD_W'(gain_damper) * PROD_W'(rate);
			neg_s2    <= pos[POS_W-1];
			zero_s2   <= (pos == '0);
		end
	end

	always_comb begin
		sum     = SUM_W'(prod_k_s2) + SUM_W'(prod_c_s2);
		// Arithmetic shift: rounds toward minus infinity.
		shifted = sum[SUM_W-1:FRAC_SHIFT];
		if (zero_s2) begin
			signed_force = '0;
		end else if (neg_s2) begin
			signed_force = -WIDE_W'(shifted);
		end else begin
			signed_force = WIDE_W'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			force_q <= sat32(signed_force);
		end
	end

endmodule

/* rtl/virtual_leader_spring_damper_force_unit.sv */
// ----------------------------------------------------------------------------
// virtual_leader_spring_damper_force_unit: per-robot spring-damper force
// Keeps per-robot formation references and deviation history and turns each
// measured offset from the virtual leader into a saturated Q16.16 force.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid / item_stall) carries one transaction per
// robot: command 0 loads the robot's reference offset, command 1 gives a
// measured offset. Only a measurement produces a transaction on the result
// channel (result_valid / result_stall); loads update state silently.
// A measurement passes from the accepted stage through the product stage
// into the result register. One transaction can be accepted every cycle
// while item_stall is low, including back-to-back transactions for the same
// robot: the per-robot state is read and written in the first stage, so
// the next transaction always sees the update of the one before it.
// When the receiver stalls, the result register holds; the two stages in
// front still fill up. Loads never enter the product stage; item_stall rises
// once a measurement waits there behind the stalled result and another
// transaction waits behind it. Reset clears all per-robot state, loads the
// spring gain with 1.0 and the damper gain with 0, and empties the pipeline.
// Gains are written through cfg_we / cfg_index / cfg_data while idle.
// ----------------------------------------------------------------------------
module virtual_leader_spring_damper_force_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vlsd_pkg::GAIN_W-1:0]     cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            command,
	input  logic [vlsd_pkg::ROBOT_W-1:0]    robot,
	input  logic signed [vlsd_pkg::POS_W-1:0] pos_x,
	input  logic signed [vlsd_pkg::POS_W-1:0] pos_y,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [vlsd_pkg::ROBOT_W-1:0]    robot_out,
	output logic signed [vlsd_pkg::POS_W-1:0] force_x,
	output logic signed [vlsd_pkg::POS_W-1:0] force_y
);
	import vlsd_pkg::*;

	// Configuration registers.
	gain_t gain_spring_q, gain_damper_q;

	// Stage 1: accepted transaction.
	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic [ROBOT_W-1:0]   robot_s1;
	pos_t                 pos_x_s1, pos_y_s1;

	// Stage 2: products in flight (measurements only).
	logic                 valid_s2;
	logic [ROBOT_W-1:0]   robot_s2;

	// Result register.
	logic                 out_valid_q;
	logic [ROBOT_W-1:0]   robot_out_q;

	logic                 load_out, load_s2, load_s1;
	logic                 in_range_s1, s1_fire;
	logic [IDX_W-1:0]     idx_s1;
	pipe_ctrl_t           ctrl;
	pos_t                 dev_x, dev_y, rate_x, rate_y;

	// Each stage moves on when the stage after it is empty or moving.
	assign load_out    = !out_valid_q || !result_stall;
	assign load_s2     = !valid_s2 || load_out;
	assign load_s1     = !valid_s1 || load_s2;
	assign item_stall  = !load_s1;

	assign in_range_s1 = (int'(robot_s1) < ROBOT_COUNT);
	assign idx_s1      = IDX_W'(robot_s1);
	assign s1_fire     = valid_s1 && load_s2;

	assign ctrl = '{load_s2: load_s2, load_out: load_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_spring_q <= GAIN_W'(256);
			gain_damper_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_SPRING: gain_spring_q <= cfg_data;
				REG_GAIN_DAMPER: gain_damper_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= item_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1 && (cmd_s1 == CMD_MEASURE) && in_range_s1;
			end
			if (load_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd_t'(command);
			robot_s1 <= robot;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
		end
		if (load_s2) begin
			robot_s2 <= robot_s1;
		end
		if (load_out) begin
			robot_out_q <= robot_s2;
		end
	end

	vlsd_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (s1_fire && in_range_s1),
		.cmd    (cmd_s1),
		.idx    (idx_s1),
		.pos_x  (pos_x_s1),
		.pos_y  (pos_y_s1),
		.dev_x  (dev_x),
		.dev_y  (dev_y),
		.rate_x (rate_x),
		.rate_y (rate_y)
	);

	vlsd_force_axis u_force_x (
		.clk         (clk),
		.ctrl        (ctrl),
		.gain_spring (gain_spring_q),
		.gain_damper (gain_damper_q),
		.dev         (dev_x),
		.rate        (rate_x),
		.pos         (pos_x_s1),
		.force_q     (force_x)
	);

	vlsd_force_axis u_force_y (
		.clk         (clk),
		.ctrl        (ctrl),
		.gain_spring (gain_spring_q),
		.gain_damper (gain_damper_q),
		.dev         (dev_y),
		.rate        (rate_y),
		.pos         (pos_y_s1),
		.force_q     (force_y)
	);

	assign result_valid = out_valid_q;
	assign robot_out    = robot_out_q;

	// The input side only backs up when every stage is full behind a stalled result.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && out_valid_q && result_stall))
		else $error("item_stall raised while the pipeline had room");

	// A load transaction never turns into a result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && (cmd_s1 == CMD_LOAD)) |=> !valid_s2)
		else $error("load transaction entered the result path");

	// A held product stage keeps its transaction.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !load_out) |=> (valid_s2 && $stable(robot_s2)))
		else $error("stage 2 transaction lost while result stalled");

endmodule
